// ===== rtl/psq_pkg.sv =====
package psq_pkg;

  // Default sizes of the queue storage.
  localparam int DEPTH_DEF         = 64;
  localparam int TAG_BITS_DEF      = 16;
  localparam int DURATION_BITS_DEF = 16;

  // Fixed widths of the request and result fields.
  localparam int REQ_W   = 2;
  localparam int TAG_W   = 16;
  localparam int DUR_W   = 16;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int SUM_W   = 22;

  // Request type codes as they arrive on the input port.
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  // Status codes of a result.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Operation after classification in the front end.
  typedef enum logic [1:0] {
    OP_APPEND,
    OP_INSERT,
    OP_REMOVE,
    OP_NONE
  } op_t;

  // One classified request as it travels from front to back.
  typedef struct packed {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [DUR_W-1:0] dur;
    logic [POS_W-1:0] idx;
  } cmd_t;

endpackage

// ===== rtl/psq_front.sv =====
module psq_front (
  input  logic                         start,
  input  logic                         q_full,
  input  logic [psq_pkg::REQ_W-1:0]    in_req_type,
  input  logic [psq_pkg::TAG_W-1:0]    in_entry_tag,
  input  logic [psq_pkg::DUR_W-1:0]    in_entry_duration,
  input  logic [psq_pkg::POS_W-1:0]    in_insert_position,
  output logic                         busy,
  output logic                         push,
  output psq_pkg::cmd_t                push_cmd
);
  import psq_pkg::*;

  // The front end holds off new requests only while the command queue is full.
  assign busy = q_full;
  assign push = start && !q_full;

  // Classify the request and turn the 1-based position into a slot index.
  always_comb begin
    push_cmd.tag = in_entry_tag;
    push_cmd.dur = in_entry_duration;
    if (in_insert_position == '0) begin
      push_cmd.idx = '0;
    end else begin
      push_cmd.idx = in_insert_position - POS_W'(1);
    end
    case (in_req_type)
      REQ_APPEND: push_cmd.op = OP_APPEND;
      REQ_INSERT: push_cmd.op = OP_INSERT;
      REQ_REMOVE: push_cmd.op = OP_REMOVE;
      default:    push_cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/psq_cmd_queue.sv =====
module psq_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  psq_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  output psq_pkg::cmd_t pop_cmd
);
  import psq_pkg::*;

  // Two-entry command queue; the back end takes an entry every cycle.
  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop       = pop_valid;
  assign pop_cmd   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/psq_back.sv =====
module psq_back #(
  parameter int DEPTH         = psq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = psq_pkg::TAG_BITS_DEF,
  parameter int DURATION_BITS = psq_pkg::DURATION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  psq_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  output logic [psq_pkg::STAT_W-1:0]    out_status,
  output logic [psq_pkg::COUNT_W-1:0]   out_entry_count,
  output logic [psq_pkg::TAG_W-1:0]     out_head_tag,
  output logic [psq_pkg::DUR_W-1:0]     out_head_duration,
  output logic [psq_pkg::SUM_W-1:0]     out_total_duration
);
  import psq_pkg::*;

  localparam int SW_TAG = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int SW_DUR = (DURATION_BITS < DUR_W) ? DURATION_BITS : DUR_W;
  localparam int OW     = $clog2(DEPTH + 1);
  localparam int CW     = (OW > POS_W) ? OW : POS_W;

  logic [SW_TAG-1:0]   slot_tag_r [DEPTH];
  logic [SW_DUR-1:0]   slot_dur_r [DEPTH];
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic                out_valid_r;
  logic                do_ins;
  logic                do_rem;
  logic [CW-1:0]       ins_pos;
  logic                q_full;
  logic                q_empty;
  logic [SW_TAG-1:0]   new_tag;
  logic [SW_DUR-1:0]   new_dur;

  assign q_full  = (occ_r == OW'(DEPTH));
  assign q_empty = (occ_r == '0);
  assign new_tag = cmd.tag[SW_TAG-1:0];
  assign new_dur = cmd.dur[SW_DUR-1:0];

  // Decide what the request does and what status it reports.
  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    status_nxt = ST_DONE;
    case (cmd.op)
      OP_APPEND, OP_INSERT: begin
        if (q_full) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins = cmd_valid;
        end
      end
      OP_REMOVE: begin
        if (q_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_rem = cmd_valid;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Target slot: the requested index if it is inside the queue, else the tail.
  always_comb begin
    if (cmd.op == OP_INSERT && CW'(cmd.idx) < CW'(occ_r)) begin
      ins_pos = CW'(cmd.idx);
    end else begin
      ins_pos = CW'(occ_r);
    end
  end

  // Occupancy and running sum of durations, kept modulo the sum width.
  always_comb begin
    occ_nxt = occ_r;
    sum_nxt = sum_r;
    if (do_ins) begin
      occ_nxt = occ_r + OW'(1);
      sum_nxt = sum_r + SUM_W'(new_dur);
    end else if (do_rem) begin
      occ_nxt = occ_r - OW'(1);
      sum_nxt = sum_r - SUM_W'(slot_dur_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      status_r <= status_nxt;
    end
  end

  // In parallel: slots past an insert shift back; all move forward on removal.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [SW_TAG-1:0] fwd_tag;
    logic [SW_DUR-1:0] fwd_dur;
    logic [SW_TAG-1:0] bwd_tag;
    logic [SW_DUR-1:0] bwd_dur;

    if (i < DEPTH - 1) begin : g_fwd
      assign fwd_tag = slot_tag_r[i+1];
      assign fwd_dur = slot_dur_r[i+1];
    end else begin : g_fwd_last
      assign fwd_tag = slot_tag_r[i];
      assign fwd_dur = slot_dur_r[i];
    end

    if (i > 0) begin : g_bwd
      assign bwd_tag = slot_tag_r[i-1];
      assign bwd_dur = slot_dur_r[i-1];
    end else begin : g_bwd_first
      assign bwd_tag = slot_tag_r[i];
      assign bwd_dur = slot_dur_r[i];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (CW'(i) == ins_pos) begin
          slot_tag_r[i] <= new_tag;
          slot_dur_r[i] <= new_dur;
        end else if (CW'(i) > ins_pos) begin
          slot_tag_r[i] <= bwd_tag;
          slot_dur_r[i] <= bwd_dur;
        end
      end else if (do_rem) begin
        slot_tag_r[i] <= fwd_tag;
        slot_dur_r[i] <= fwd_dur;
      end
    end
  end

  // The result shows the state left by the request just carried out.
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_entry_count    = COUNT_W'(occ_r);
  assign out_head_tag       = q_empty ? '0 : TAG_W'(slot_tag_r[0]);
  assign out_head_duration  = q_empty ? '0 : DUR_W'(slot_dur_r[0]);
  assign out_total_duration = sum_r;

  // A refusal for a full queue is reported only with a full queue.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> q_full)
    else $error("full status reported while queue is not full");

  // A refusal for an empty queue is reported only with an empty queue.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> q_empty)
    else $error("empty status reported while queue holds entries");

  // An accepted insert or append grows the queue by exactly one entry.
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (occ_r == $past(occ_r) + OW'(1)))
    else $error("insert did not grow the occupancy by one");

  // An empty queue always has a zero duration total.
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (sum_r == '0))
    else $error("empty queue with nonzero duration total");

  // Occupancy never passes the depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (do_ins || do_rem) |=> (occ_r <= OW'(DEPTH)))
    else $error("occupancy beyond depth");

endmodule

// ===== rtl/positional_insert_shift_queue.sv =====
// Positional-insert shift queue. A request (append at the tail, insert at a
// 1-based position, or remove the head) is taken at a clock edge where start
// is high and busy is low, and its result follows through the command queue
// and the result registers: out_valid is high for exactly one cycle with the
// status, the entry count, the head entry and the total of all durations held.
// The receiver cannot stall; every result must be taken in its strobe cycle.
// A request enters a two-entry command queue and is carried out by the back
// end, where the slots shift in parallel, so one request is completed per
// cycle and busy stays low in steady operation. Position zero acts as position
// one, and a position past the tail appends. Inserts into a full queue and
// removals from an empty one are refused and leave the contents unchanged.
module positional_insert_shift_queue #(
  parameter int DEPTH         = psq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = psq_pkg::TAG_BITS_DEF,
  parameter int DURATION_BITS = psq_pkg::DURATION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [psq_pkg::REQ_W-1:0]     in_req_type,
  input  logic [psq_pkg::TAG_W-1:0]     in_entry_tag,
  input  logic [psq_pkg::DUR_W-1:0]     in_entry_duration,
  input  logic [psq_pkg::POS_W-1:0]     in_insert_position,
  output logic                          out_valid,
  output logic [psq_pkg::STAT_W-1:0]    out_status,
  output logic [psq_pkg::COUNT_W-1:0]   out_entry_count,
  output logic [psq_pkg::TAG_W-1:0]     out_head_tag,
  output logic [psq_pkg::DUR_W-1:0]     out_head_duration,
  output logic [psq_pkg::SUM_W-1:0]     out_total_duration
);
  import psq_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop_valid;
  cmd_t pop_cmd;

  // Front end: request handshake and classification.
  psq_front u_front (
    .start              (start),
    .q_full             (q_full),
    .in_req_type        (in_req_type),
    .in_entry_tag       (in_entry_tag),
    .in_entry_duration  (in_entry_duration),
    .in_insert_position (in_insert_position),
    .busy               (busy),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  // Command queue between front and back.
  psq_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  // Back end: slot storage, shifting and result.
  psq_back #(
    .DEPTH         (DEPTH),
    .TAG_BITS      (TAG_BITS),
    .DURATION_BITS (DURATION_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (pop_valid),
    .cmd                (pop_cmd),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_head_tag       (out_head_tag),
    .out_head_duration  (out_head_duration),
    .out_total_duration (out_total_duration)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import psq_pkg::*;

  // Request code that the block ignores; it still gets one result.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int QUEUE_DEPTH    = DEPTH_DEF;
  localparam int TARGET_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // Stimulus segments steer the fill level toward full, toward empty, or neither.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [TAG_W-1:0] tag;
    logic [DUR_W-1:0] dur;
    logic [POS_W-1:0] pos;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic [TAG_W-1:0]   head_tag;
    logic [DUR_W-1:0]   head_dur;
    logic [SUM_W-1:0]   total;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type = '0;
  logic [TAG_W-1:0]   in_entry_tag = '0;
  logic [DUR_W-1:0]   in_entry_duration = '0;
  logic [POS_W-1:0]   in_insert_position = '0;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [COUNT_W-1:0] out_entry_count;
  logic [TAG_W-1:0]   out_head_tag;
  logic [DUR_W-1:0]   out_head_duration;
  logic [SUM_W-1:0]   out_total_duration;

  positional_insert_shift_queue i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_entry_tag       (in_entry_tag),
    .in_entry_duration  (in_entry_duration),
    .in_insert_position (in_insert_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_head_tag       (out_head_tag),
    .out_head_duration  (out_head_duration),
    .out_total_duration (out_total_duration)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue contents.
  logic [TAG_W-1:0] shadow_tags [QUEUE_DEPTH];
  logic [DUR_W-1:0] shadow_durs [QUEUE_DEPTH];
  int               fill_level = 0;
  logic [SUM_W-1:0] dur_total = '0;

  request_t      req_backlog [$];
  queue_result_t expected_results [$];

  int total_items = 0;
  int accepted_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int n_append = 0, n_insert = 0, n_remove = 0, n_unused = 0;
  int n_full = 0, n_empty = 0, peak_count = 0;

  logic     req_taken = 1'b0;
  int       burst_left = 1;
  int       gap_left = 0;
  request_t drive_req;

  // Applies one request to the shadow queue and returns the result it should give.
  function automatic queue_result_t apply_request(request_t rq);
    queue_result_t res;
    int slot;
    res.status = ST_DONE;
    if (rq.kind == REQ_APPEND || rq.kind == REQ_INSERT) begin
      if (fill_level >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        slot = fill_level;
        // Position zero means the head; a position past the tail appends.
        if (rq.kind == REQ_INSERT) begin
          if (rq.pos == 0) slot = 0;
          else if (int'(rq.pos) - 1 < fill_level) slot = int'(rq.pos) - 1;
        end
        for (int i = fill_level; i > slot; i--) begin
          shadow_tags[i] = shadow_tags[i-1];
          shadow_durs[i] = shadow_durs[i-1];
        end
        shadow_tags[slot] = rq.tag;
        shadow_durs[slot] = rq.dur;
        fill_level++;
        dur_total = dur_total + SUM_W'(rq.dur);
      end
    end else if (rq.kind == REQ_REMOVE) begin
      if (fill_level == 0) begin
        res.status = ST_EMPTY;
      end else begin
        dur_total = dur_total - SUM_W'(shadow_durs[0]);
        for (int i = 1; i < fill_level; i++) begin
          shadow_tags[i-1] = shadow_tags[i];
          shadow_durs[i-1] = shadow_durs[i];
        end
        fill_level--;
      end
    end
    res.count    = COUNT_W'(fill_level);
    res.head_tag = (fill_level > 0) ? shadow_tags[0] : '0;
    res.head_dur = (fill_level > 0) ? shadow_durs[0] : '0;
    res.total    = dur_total;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 60) $display("MISMATCH: %s", msg);
  endtask

  task automatic add_request(input logic [REQ_W-1:0] kind, input logic [TAG_W-1:0] tag,
                             input logic [DUR_W-1:0] dur, input logic [POS_W-1:0] pos);
    request_t rq;
    rq.kind = kind;
    rq.tag  = tag;
    rq.dur  = dur;
    rq.pos  = pos;
    req_backlog.push_back(rq);
    total_items++;
  endtask

  // Field values lean toward the extremes now and then.
  function automatic logic [15:0] pick_word();
    int roll;
    roll = $urandom_range(9, 0);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(4, 0))
      0: return '0;
      1: return POS_W'(QUEUE_DEPTH);
      2: return POS_W'($urandom_range(8, 1));
      default: return POS_W'($urandom_range(QUEUE_DEPTH, 0));
    endcase
  endfunction

  // Driver: presents requests in bursts with random gaps, changing at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !req_taken) begin
        // The block is busy; hold the current request.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        drive_req = req_backlog.pop_front();
        in_req_type        <= drive_req.kind;
        in_entry_tag       <= drive_req.tag;
        in_entry_duration  <= drive_req.dur;
        in_insert_position <= drive_req.pos;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted request, checks each result, and
  // watches for a stuck handshake.
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    request_t rq;
    req_taken <= start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        rq.kind = in_req_type;
        rq.tag  = in_entry_tag;
        rq.dur  = in_entry_duration;
        rq.pos  = in_insert_position;
        want = apply_request(rq);
        expected_results.push_back(want);
        accepted_count++;
        case (rq.kind)
          REQ_APPEND: n_append++;
          REQ_INSERT: n_insert++;
          REQ_REMOVE: n_remove++;
          default:    n_unused++;
        endcase
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_EMPTY) n_empty++;
        if (fill_level > peak_count) peak_count = fill_level;
      end

      if (out_valid) begin
        got.status   = out_status;
        got.count    = out_entry_count;
        got.head_tag = out_head_tag;
        got.head_dur = out_head_duration;
        got.total    = out_total_duration;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      result_count, got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                      result_count, got.count, want.count));
          if (got.head_tag !== want.head_tag)
            report_mismatch($sformatf("result %0d head_tag %h, expected %h",
                                      result_count, got.head_tag, want.head_tag));
          if (got.head_dur !== want.head_dur)
            report_mismatch($sformatf("result %0d head_duration %h, expected %h",
                                      result_count, got.head_dur, want.head_dur));
          if (got.total !== want.total)
            report_mismatch($sformatf("result %0d total_duration %h, expected %h",
                                      result_count, got.total, want.total));
        end
        result_count++;
      end

      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int mode;
    int seg_len;
    int add_pct;
    logic [REQ_W-1:0] kind;

    // Directed part: empty removal, ignored code, extremes, every kind of insert.
    add_request(REQ_REMOVE, 16'h0000, 16'h0000, 7'd0);
    add_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 7'd64);
    add_request(REQ_APPEND, 16'h0000, 16'h0000, 7'd0);
    add_request(REQ_APPEND, 16'hFFFF, 16'hFFFF, 7'd0);
    add_request(REQ_INSERT, 16'h1234, 16'h0101, 7'd0);
    add_request(REQ_INSERT, 16'h2345, 16'h0202, 7'd1);
    add_request(REQ_INSERT, 16'h3456, 16'h0303, 7'd64);
    add_request(REQ_INSERT, 16'h4567, 16'h0404, 7'd3);
    add_request(REQ_INSERT, 16'h5678, 16'h0505, 7'd6);
    add_request(REQ_UNUSED, 16'hAAAA, 16'h5555, 7'd1);
    repeat (3) add_request(REQ_REMOVE, 16'hFFFF, 16'hFFFF, 7'd127);
    add_request(REQ_INSERT, 16'hAAAA, 16'h5555, 7'd2);
    add_request(REQ_APPEND, 16'h5555, 16'hAAAA, 7'd0);
    add_request(REQ_INSERT, 16'h0F0F, 16'hF0F0, 7'd7);
    repeat (7) add_request(REQ_REMOVE, 16'h0000, 16'h0000, 7'd0);
    add_request(REQ_REMOVE, 16'h0000, 16'h0000, 7'd0);

    // Random part: segments that push toward full, toward empty, or wander.
    while (total_items < TARGET_ITEMS) begin
      mode = $urandom_range(MODE_MIXED, MODE_FILL);
      seg_len = $urandom_range(150, 20);
      add_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 15 : 50;
      for (int k = 0; k < seg_len; k++) begin
        if ($urandom_range(99, 0) < 2) kind = REQ_UNUSED;
        else if ($urandom_range(99, 0) < add_pct)
          kind = ($urandom_range(1, 0) == 0) ? REQ_APPEND : REQ_INSERT;
        else kind = REQ_REMOVE;
        add_request(kind, pick_word(), pick_word(), pick_position());
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!(accepted_count == total_items && expected_results.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));

    $display("Ran %0d requests: %0d appends, %0d inserts, %0d removals, %0d unused codes.",
             accepted_count, n_append, n_insert, n_remove, n_unused);
    $display("Refusals: %0d on a full queue, %0d on an empty one; peak fill %0d of %0d.",
             n_full, n_empty, peak_count, QUEUE_DEPTH);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
